// File: sv/dss_pkg.sv
// Shared types and constants for the disk seek scheduler.
// No dependencies; imported by dss_scan, dss_out and disk_seek_scheduler.
package dss_pkg;

   localparam int CYL_W      = 16;
   localparam int WAIT_W     = 6;
   localparam int TOTAL_W    = 22;
   localparam int IDX_OUT_W  = 5;
   localparam int ENTRY_W    = 1 + WAIT_W + CYL_W;
   localparam int SERVED_BIT = ENTRY_W - 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int RSP_DATA_W = 80;

   localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

   localparam logic [2:0] MODE_FCFS  = 3'd0;
   localparam logic [2:0] MODE_SSTF  = 3'd1;
   localparam logic [2:0] MODE_SCAN  = 3'd2;
   localparam logic [2:0] MODE_CSCAN = 3'd3;
   localparam logic [2:0] MODE_LOOK  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CCOUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT  = 3'd4;

   // Segment of a batch run: what the current pass over the store selects.
   typedef enum logic [3:0] {
      SEG_FIRST,
      SEG_SSTF,
      SEG_HI_ASC,
      SEG_HI_DESC,
      SEG_LO_ASC,
      SEG_LO_DESC,
      SEG_TO_LAST,
      SEG_TO_ZERO,
      SEG_DONE
   } seg_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic              found;
      logic              aged;
      logic [WAIT_W-1:0] wait_cnt;
      logic [CYL_W-1:0]  cyl;
   } pick_type;

   typedef struct packed {
      logic [CYL_W-1:0]     to_cyl;
      logic [IDX_OUT_W-1:0] req_index;
      logic                 has_index;
      logic                 aged;
   } step_type;

endpackage

// File: sv/dss_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dss_ram #(
   parameter int WIDTH = 23,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dss_scan.sv
// Selection unit: looks at one store entry per cycle during a pass and keeps
// the best candidate for the current segment. Depends on dss_pkg.
module dss_scan #(
   parameter int MAX_REQ = 32,
   localparam int IW = $clog2(MAX_REQ)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             valid,
   input  logic [IW-1:0]                    idx,
   input  logic [dss_pkg::ENTRY_W-1:0]      entry,
   input  dss_pkg::seg_type                 kind,
   input  logic [dss_pkg::CYL_W-1:0]        head,
   input  logic [dss_pkg::CYL_W-1:0]        base,
   input  logic [dss_pkg::WAIT_W-1:0]       limit,
   output logic                             wb_en,
   output logic [dss_pkg::ENTRY_W-1:0]      wb_data,
   output dss_pkg::pick_type                pick,
   output logic [IW-1:0]                    pick_idx
);
   import dss_pkg::*;

   logic              found_ff, afound_ff;
   logic [CYL_W-1:0]  best_ff, bcyl_ff, acyl_ff;
   logic [IW-1:0]     bidx_ff, aidx_ff;
   logic [WAIT_W-1:0] bwait_ff, await_ff;

   logic              served, is_hi, in_set, desc, cand, better, aged_hit;
   logic [WAIT_W-1:0] w, w_inc;
   logic [CYL_W-1:0]  c, delta, key;

   always_comb begin
      served = entry[SERVED_BIT];
      w      = entry[SERVED_BIT-1:CYL_W];
      c      = entry[CYL_W-1:0];
      w_inc  = (served || (w == WAIT_MAX)) ? w : w + 1'b1;
      delta  = (c > head) ? c - head : head - c;
      is_hi  = c > base;
      key    = (kind == SEG_SSTF) ? delta : c;
      case (kind) inside
         SEG_FIRST, SEG_SSTF:     in_set = 1'b1;
         SEG_HI_ASC, SEG_HI_DESC: in_set = is_hi;
         SEG_LO_ASC, SEG_LO_DESC: in_set = !is_hi;
         default:                 in_set = 1'b0;
      endcase
      desc   = (kind == SEG_HI_DESC) || (kind == SEG_LO_DESC);
      cand   = valid && !served && in_set;
      // strict compares keep the lowest index on ties
      if (!found_ff) begin
         better = 1'b1;
      end else if (kind == SEG_FIRST) begin
         better = 1'b0;
      end else begin
         better = desc ? (key > best_ff) : (key < best_ff);
      end
      aged_hit = valid && (kind == SEG_SSTF) && !served && (w_inc >= limit);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         found_ff  <= 1'b0;
         afound_ff <= 1'b0;
      end else begin
         if (cand && better) begin
            found_ff <= 1'b1;
         end
         if (aged_hit) begin
            afound_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cand && better) begin
         best_ff  <= key;
         bidx_ff  <= idx;
         bcyl_ff  <= c;
         bwait_ff <= w_inc;
      end
      if (aged_hit && !afound_ff) begin
         aidx_ff  <= idx;
         acyl_ff  <= c;
         await_ff <= w_inc;
      end
   end

   assign wb_en   = valid && (kind == SEG_SSTF);
   assign wb_data = {served, w_inc, c};

   always_comb begin
      pick.found    = found_ff || afound_ff;
      pick.aged     = afound_ff;
      pick.wait_cnt = afound_ff ? await_ff : bwait_ff;
      pick.cyl      = afound_ff ? acyl_ff : bcyl_ff;
      pick_idx      = afound_ff ? aidx_ff : bidx_ff;
   end

endmodule

// File: sv/dss_out.sv
// Step builder and result register: tracks head and seek total, holds one
// step back so the last beat of a batch can carry tlast. Depends on dss_pkg.
module dss_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              init,
   input  logic [dss_pkg::CYL_W-1:0]         start_pos,
   input  logic                              push,
   input  dss_pkg::step_type                 step,
   input  logic                              finish,
   output logic                              can_push,
   output logic [dss_pkg::CYL_W-1:0]         head,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [dss_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // from, to, seek_len, req_index, running_total
   output logic [1:0]                        rsp_tuser,  // has_index, aged
   output logic                              rsp_tlast   // end_of_run
);
   import dss_pkg::*;

   localparam int PAD_W = RSP_DATA_W - (3 * CYL_W + IDX_OUT_W + TOTAL_W);

   logic [CYL_W-1:0]   head_ff, head_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff;

   logic [CYL_W-1:0]     pend_from_ff, pend_to_ff, pend_seek_ff;
   logic [IDX_OUT_W-1:0] pend_idx_ff;
   logic                 pend_has_ff, pend_aged_ff;
   logic [TOTAL_W-1:0]   pend_total_ff;

   logic [CYL_W-1:0]     rsp_from_ff, rsp_to_ff, rsp_seek_ff;
   logic [IDX_OUT_W-1:0] rsp_idx_ff;
   logic                 rsp_has_ff, rsp_aged_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;

   logic             slot_free, move;
   logic [CYL_W-1:0] seek_delta;

   always_comb begin
      slot_free  = !rsp_valid_ff || rsp_tready;
      can_push   = !pend_valid_ff || slot_free;
      move       = pend_valid_ff && slot_free && (push || finish);
      seek_delta = (step.to_cyl > head_ff) ? step.to_cyl - head_ff : head_ff - step.to_cyl;

      head_in  = head_ff;
      total_in = total_ff;
      if (init) begin
         head_in  = start_pos;
         total_in = '0;
      end else if (push) begin
         head_in  = step.to_cyl;
         total_in = total_ff + TOTAL_W'(seek_delta);
      end

      pend_valid_in = pend_valid_ff;
      if (push) begin
         pend_valid_in = 1'b1;
      end else if (finish && slot_free) begin
         pend_valid_in = 1'b0;
      end

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         total_ff      <= total_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pend_from_ff  <= head_ff;
         pend_to_ff    <= step.to_cyl;
         pend_seek_ff  <= seek_delta;
         pend_idx_ff   <= step.req_index;
         pend_has_ff   <= step.has_index;
         pend_aged_ff  <= step.aged;
         pend_total_ff <= total_in;
      end
      if (move) begin
         rsp_from_ff  <= pend_from_ff;
         rsp_to_ff    <= pend_to_ff;
         rsp_seek_ff  <= pend_seek_ff;
         rsp_idx_ff   <= pend_idx_ff;
         rsp_has_ff   <= pend_has_ff;
         rsp_aged_ff  <= pend_aged_ff;
         rsp_total_ff <= pend_total_ff;
         rsp_last_ff  <= finish;
      end
   end

   assign head       = head_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_total_ff, rsp_idx_ff, rsp_seek_ff, rsp_to_ff,
                        rsp_from_ff};
   assign rsp_tuser  = {rsp_aged_ff, rsp_has_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: sv/disk_seek_scheduler.sv
// Disk seek scheduler. Requests load one per beat into a request memory; the beat with
// tlast set is stored too and starts the batch, which emits one result beat per head move
// (FCFS, SSTF with aging, SCAN, C-SCAN or LOOK per the mode register). During a batch
// every served request costs one pass over the n stored entries (n reads, a drain of the
// memory's registered read and a decision) followed by an emit step; each scanning
// segment ends with one further empty pass, each disk-end move is an emit step and the
// final hand-off is a flush step; input is held off until the last beat has been handed
// to the result register. Requests beyond MAX_REQ are dropped.
// Depends on dss_pkg, dss_ram, dss_scan, dss_out.
module disk_seek_scheduler #(
   parameter int MAX_REQ  = 32,
   parameter int CYL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dss_pkg::CYL_W-1:0]           req_tdata,   // cylinder
   input  logic                                req_tlast,   // final_request
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dss_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // from_cyl, to_cyl, seek_len,
                                                            // req_index, running_total
   output logic [1:0]                          rsp_tuser,   // has_index, aged
   output logic                                rsp_tlast,   // end_of_run
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dss_pkg::*;

   localparam int IW = $clog2(MAX_REQ);
   localparam int CW = $clog2(MAX_REQ + 1);
   localparam int CB = (CYL_BITS < CYL_W) ? CYL_BITS : CYL_W;
   localparam logic [CYL_W-1:0] CYL_MASK = CYL_W'((33'd1 << CB) - 33'd1);

   logic [2:0]            mode_ff;
   logic                  right_ff;
   logic [CYL_W-1:0]      start_ff;
   logic [CSR_DATA_W-1:0] ccount_ff;
   logic [WAIT_W-1:0]     limit_ff;

   state_type       state_ff, state_in;
   seg_type         seg_ff, seg_in, nseg;
   logic [CW-1:0]   rd_ff, rd_in, cnt_ff, cnt_in;
   logic            pv_ff;
   logic [IW-1:0]   pidx_ff;

   logic                  req_accept, full, issue, pass_done, at_end, restart;
   logic [CSR_DATA_W-1:0] last_m1;
   logic [CYL_W-1:0]      last_cyl, base;

   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic               wb_en;
   logic [ENTRY_W-1:0] wb_data;
   pick_type           pick;
   logic [IW-1:0]      pick_idx;

   logic             out_init, push, finish, can_push;
   step_type         step;
   logic [CYL_W-1:0] head;

   function automatic seg_type first_seg(input logic [2:0] md, input logic rt);
      case (md)
         MODE_SSTF:                        first_seg = SEG_SSTF;
         MODE_SCAN, MODE_CSCAN, MODE_LOOK: first_seg = rt ? SEG_HI_ASC : SEG_LO_DESC;
         default:                          first_seg = SEG_FIRST;
      endcase
   endfunction

   // Segment order of the sweep modes; at_end tells whether the head already sits
   // at the disk end SCAN would travel to.
   function automatic seg_type next_seg(input seg_type sg, input logic [2:0] md,
                                        input logic rt, input logic ae);
      next_seg = SEG_DONE;
      case (sg)
         SEG_HI_ASC:
            if (rt) begin
               if (md == MODE_SCAN) begin
                  next_seg = ae ? SEG_LO_DESC : SEG_TO_LAST;
               end else if (md == MODE_CSCAN) begin
                  next_seg = SEG_TO_LAST;
               end else begin
                  next_seg = SEG_LO_DESC;
               end
            end
         SEG_LO_DESC:
            if (!rt) begin
               if (md == MODE_SCAN) begin
                  next_seg = ae ? SEG_HI_ASC : SEG_TO_ZERO;
               end else if (md == MODE_CSCAN) begin
                  next_seg = SEG_TO_ZERO;
               end else begin
                  next_seg = SEG_HI_ASC;
               end
            end
         SEG_TO_LAST:
            if (rt) begin
               next_seg = (md == MODE_SCAN) ? SEG_LO_DESC : SEG_TO_ZERO;
            end else begin
               next_seg = SEG_HI_DESC;
            end
         SEG_TO_ZERO:
            if (rt) begin
               next_seg = SEG_LO_ASC;
            end else begin
               next_seg = (md == MODE_SCAN) ? SEG_HI_ASC : SEG_TO_LAST;
            end
         default: next_seg = SEG_DONE;
      endcase
   endfunction

   function automatic state_type seg_state(input seg_type sg);
      unique case (sg)
         SEG_TO_LAST, SEG_TO_ZERO: seg_state = ST_EMIT;
         SEG_DONE:                 seg_state = ST_FLUSH;
         default:                  seg_state = ST_SCAN;
      endcase
   endfunction

   function automatic logic seg_scans(input seg_type sg);
      seg_scans = (sg != SEG_TO_LAST) && (sg != SEG_TO_ZERO) && (sg != SEG_DONE);
   endfunction

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FCFS;
         right_ff  <= 1'b1;
         start_ff  <= '0;
         ccount_ff <= CSR_DATA_W'(200);
         limit_ff  <= WAIT_W'(4);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_data[2:0];
            REG_RIGHT:  right_ff  <= csr_data[0];
            REG_START:  start_ff  <= csr_data[CYL_W-1:0];
            REG_CCOUNT: ccount_ff <= csr_data;
            REG_LIMIT:  limit_ff  <= csr_data[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      last_m1   = (ccount_ff == '0) ? '0 : ccount_ff - 1'b1;
      last_cyl  = (last_m1 > {1'b0, CYL_MASK}) ? CYL_MASK : last_m1[CYL_W-1:0];
      base      = start_ff & CYL_MASK;
      at_end    = right_ff ? (head == last_cyl) : (head == '0);
      req_accept = req_tvalid && req_tready;
      full      = cnt_ff >= CW'(MAX_REQ);
      issue     = (state_ff == ST_SCAN) && (rd_ff < cnt_ff);
      pass_done = (state_ff == ST_SCAN) && !issue && !pv_ff;
      nseg      = next_seg(seg_ff, mode_ff, right_ff, at_end);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      rd_in    = rd_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_LOAD:
            if (req_accept) begin
               if (!full) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_tlast) begin
                  seg_in   = first_seg(mode_ff, right_ff);
                  state_in = seg_state(seg_in);
                  rd_in    = '0;
               end
            end
         ST_SCAN:
            if (issue) begin
               rd_in = rd_ff + 1'b1;
            end else if (!pv_ff) begin
               if (pick.found) begin
                  state_in = ST_EMIT;
               end else begin
                  seg_in   = nseg;
                  state_in = seg_state(nseg);
                  rd_in    = '0;
               end
            end
         ST_EMIT:
            if (can_push) begin
               if (seg_scans(seg_ff)) begin
                  state_in = ST_SCAN;
                  rd_in    = '0;
               end else begin
                  seg_in   = nseg;
                  state_in = seg_state(nseg);
                  rd_in    = '0;
               end
            end
         ST_FLUSH:
            if (can_push) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
            end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         seg_ff   <= SEG_DONE;
         rd_ff    <= '0;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         rd_ff    <= rd_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= issue;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= rd_ff[IW-1:0];
   end

   // outputs
   always_comb begin
      req_tready = state_ff == ST_LOAD;
      restart    = (state_in == ST_SCAN) && ((state_ff != ST_SCAN) || pass_done);

      ram_we    = 1'b0;
      ram_waddr = cnt_ff[IW-1:0];
      ram_wdata = {1'b0, {WAIT_W{1'b0}}, req_tdata & CYL_MASK};
      if (req_accept && !full) begin
         ram_we = 1'b1;
      end else if (wb_en) begin
         ram_we    = 1'b1;
         ram_waddr = pidx_ff;
         ram_wdata = wb_data;
      end else if (pass_done && pick.found) begin
         // mark the chosen request served
         ram_we    = 1'b1;
         ram_waddr = pick_idx;
         ram_wdata = {1'b1, pick.wait_cnt, pick.cyl};
      end

      out_init = req_accept && req_tlast;
      push     = (state_ff == ST_EMIT) && can_push;
      finish   = state_ff == ST_FLUSH;

      step.has_index = (seg_ff == SEG_FIRST) || (seg_ff == SEG_SSTF);
      step.aged      = (seg_ff == SEG_SSTF) && pick.aged;
      step.req_index = step.has_index ? IDX_OUT_W'(pick_idx) : '0;
      case (seg_ff)
         SEG_TO_LAST: step.to_cyl = last_cyl;
         SEG_TO_ZERO: step.to_cyl = '0;
         default:     step.to_cyl = pick.cyl;
      endcase
   end

   dss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REQ)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   dss_scan #(
      .MAX_REQ (MAX_REQ)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (restart),
      .valid    (pv_ff),
      .idx      (pidx_ff),
      .entry    (ram_rdata),
      .kind     (seg_ff),
      .head     (head),
      .base     (base),
      .limit    (limit_ff),
      .wb_en    (wb_en),
      .wb_data  (wb_data),
      .pick     (pick),
      .pick_idx (pick_idx)
   );

   dss_out u_out (
      .clock      (clock),
      .reset      (reset),
      .init       (out_init),
      .start_pos  (base),
      .push       (push),
      .step       (step),
      .finish     (finish),
      .can_push   (can_push),
      .head       (head),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
